/* hdl/assert_macros.svh */
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold in the same cycle as trig
`define FYS_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("fys assertion failed");

// cond must hold in the cycle after trig
`define FYS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("fys assertion failed");

`endif

/* hdl/fys_pkg.sv */
`default_nettype none
package fys_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int CODE_WIDTH_DEF  = 8;

  localparam int MODE_W     = 2;
  localparam int ITEM_W     = 8;
  localparam int RAND_W     = 32;
  localparam int OUT_CODE_W = 8;
  localparam int POS_W      = 6;

  // remainder unit: quotient bits retired per cycle
  localparam int MOD_DIGITS = 4;
  localparam int MOD_STEPS  = RAND_W / MOD_DIGITS;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_SWAP = 2'd1,
    MODE_EMIT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_t;

endpackage
`default_nettype wire

/* hdl/fys_ifs.sv */
`default_nettype none
interface fys_in_if import fys_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ITEM_W-1:0] item_code;
  logic [RAND_W-1:0] random_word;

  modport source (output valid, mode, item_code, random_word, input ready);
  modport sink   (input valid, mode, item_code, random_word, output ready);
endinterface

interface fys_out_if import fys_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_CODE_W-1:0] out_code;
  logic [POS_W-1:0]      out_position;
  logic                  last;

  modport source (output valid, out_code, out_position, last, input ready);
  modport sink   (input valid, out_code, out_position, last, output ready);
endinterface
`default_nettype wire

/* hdl/fisher_yates_shuffler.sv */
// channel | dir | signals                                 | request moves
// in_ch   | in  | valid ready mode item_code random_word   | load, swap step or emit
// out_ch  | out | valid ready out_code out_position last  | one list entry
//
// Load: the item is written from idle. Swap step: the remainder unit runs, then
// the read-read-write-write of the item store (one read port, one write
// port). Emit: per entry a store read, an output load, then output wait.
// rst_n is synchronous; count and swap index clear, the store keeps contents.
// in_ch.ready is low while a request is in progress; out_ch stalls hold state.
`default_nettype none
`include "assert_macros.svh"
module fisher_yates_shuffler import fys_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int CODE_WIDTH  = CODE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fys_in_if.sink      in_ch,
  fys_out_if.source   out_ch
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [CODE_WIDTH-1:0] mem [STORE_DEPTH];
  logic [CODE_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [CODE_WIDTH-1:0] mem_wdata;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic [CODE_WIDTH-1:0] tmp_r, tmp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_CODE_W-1:0] out_code_r;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_last_r;

  logic                  in_fire;
  logic                  out_fire;
  logic                  emit_last;
  logic                  mod_start;
  logic                  mod_done;
  logic [CW-1:0]         mod_rem;

  fys_mod_unit #(
    .CNT_W (CW)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_ch.random_word),
    .divisor   (count_r - idx_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign in_ch.ready         = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_fire            = out_valid_r && out_ch.ready;
  assign emit_last           = (CW'(k_r) == count_r - 1'b1);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_code     = out_code_r;
  assign out_ch.out_position = out_pos_r;
  assign out_ch.last         = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = rd_data_r;
    mem_raddr     = k_r;
    mod_start     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.mode)
            MODE_LOAD: begin
              if (count_r < CW'(STORE_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = CODE_WIDTH'(in_ch.item_code);
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_SWAP: begin
              if (idx_r < count_r) begin
                mod_start = 1'b1;
                state_nxt = S_MOD;
              end
            end
            MODE_EMIT: begin
              if (count_r == '0) begin
                idx_nxt = '0;
              end else begin
                k_nxt     = '0;
                state_nxt = S_EMIT_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          j_nxt     = AW'(idx_r + mod_rem);
          mem_raddr = idx_r[AW-1:0];
          state_nxt = S_RD_J;
        end
      end
      S_RD_J: begin
        mem_raddr = j_r;
        tmp_nxt   = rd_data_r;
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rd_data_r;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = tmp_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT_RD: begin
        mem_raddr = k_r;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_fire) begin
          out_valid_nxt = 1'b0;
          if (emit_last) begin
            count_nxt = '0;
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    tmp_r <= tmp_nxt;
    if (state_r == S_EMIT_LD) begin
      out_code_r <= OUT_CODE_W'(rd_data_r);
      out_pos_r  <= POS_W'(k_r);
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  `FYS_ASSERT_SAME(a_ready_no_pending, in_ch.ready, !out_ch.valid)
  `FYS_ASSERT_SAME(a_idx_within_count, 1'b1, idx_r <= count_r)
  `FYS_ASSERT_NEXT(a_last_clears_list, out_fire && out_ch.last, count_r == '0 && idx_r == '0)

endmodule
`default_nettype wire

/* hdl/fys_mod_unit.sv */
`default_nettype none
module fys_mod_unit import fys_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CNT_W-1:0]  remainder
);

  localparam int STEP_W = $clog2(MOD_STEPS);

  logic [RAND_W-1:0] word_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_step;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W:0]    wide;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  // restoring remainder, MOD_DIGITS bits per cycle, MSB first
  always_comb begin
    acc  = rem_r;
    wide = '0;
    for (int b = 0; b < MOD_DIGITS; b++) begin
      wide = {acc, word_r[RAND_W-1-b]};
      if (wide >= {1'b0, div_r}) begin
        wide = wide - {1'b0, div_r};
      end
      acc = wide[CNT_W-1:0];
    end
    rem_step = acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= dividend;
      div_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      word_r <= word_r << MOD_DIGITS;
      rem_r  <= rem_step;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top import fys_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 3 * STORE_DEPTH_DEF + 16;
  localparam int TARGET_TAKEN = 150;
  localparam int ENTRY_DEPTH = 256;

  // exp_n: -1 = use the shuffle model, 0 = no entries, 1 = a single entry exp_code
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ITEM_W-1:0]     code;
    logic [RAND_W-1:0]     rnd;
    int                    exp_n;
    logic [OUT_CODE_W-1:0] exp_code;
  } dir_row_t;

  typedef struct packed {
    logic [OUT_CODE_W-1:0] code;
    logic [POS_W-1:0]      pos;
    logic                  last;
  } entry_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{MODE_EMIT,   8'h00, 32'h0000_0000,  0, 8'h00},
    '{MODE_SWAP,   8'h00, 32'hFFFF_FFFF, -1, 8'h00},
    '{MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, -1, 8'h00},
    '{MODE_LOAD,   8'hFF, 32'h0000_0000, -1, 8'h00},
    '{MODE_EMIT,   8'h00, 32'h0000_0000,  1, 8'hFF},
    '{MODE_LOAD,   8'h00, 32'hFFFF_FFFF, -1, 8'h00},
    '{MODE_SWAP,   8'hFF, 32'hFFFF_FFFF, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h0000_0000, -1, 8'h00},
    '{MODE_EMIT,   8'h00, 32'h0000_0000,  1, 8'h00},
    '{MODE_LOAD,   8'h01, 32'h0000_0000, -1, 8'h00},
    '{MODE_LOAD,   8'h80, 32'h0000_0000, -1, 8'h00},
    '{MODE_LOAD,   8'h7F, 32'h0000_0000, -1, 8'h00},
    '{MODE_LOAD,   8'hAA, 32'h0000_0000, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h0000_0000, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'hFFFF_FFFF, -1, 8'h00},
    '{MODE_LOAD,   8'h55, 32'h0000_0000, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h8000_0000, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h7FFF_FFFF, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h1234_5678, -1, 8'h00},
    '{MODE_SWAP,   8'h00, 32'h0000_0000, -1, 8'h00},
    '{MODE_EMIT,   8'h00, 32'h0000_0000, -1, 8'h00}
  };

  logic clk;
  logic rst_n;

  fys_in_if  in_ch ();
  fys_out_if out_ch ();

  fisher_yates_shuffler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shuffle model state
  logic [ITEM_W-1:0] shuffle_store [STORE_DEPTH_DEF];
  int unsigned       list_len;
  int unsigned       fix_pos;
  entry_t            pending_entries [ENTRY_DEPTH];
  int unsigned       entry_wr;
  int unsigned       entry_rd;

  int  fail_count;
  int  taken_count;
  int  cycle_count;
  bit  steady_run;
  bit  full_list_done;
  entry_t want_entry;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_entry(input entry_t e);
    pending_entries[entry_wr % ENTRY_DEPTH] = e;
    entry_wr++;
  endfunction

  function automatic int unsigned pending_count();
    return entry_wr - entry_rd;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // updates the shuffle model; returns 1 for an emit or for a load or swap that took effect
  function automatic bit apply_request(input logic [MODE_W-1:0] m,
                                       input logic [ITEM_W-1:0] c,
                                       input logic [RAND_W-1:0] r,
                                       input bit predict);
    int unsigned span;
    int unsigned j;
    logic [ITEM_W-1:0] held;
    entry_t e;
    apply_request = 1'b0;
    case (m)
      MODE_LOAD: begin
        if (list_len < STORE_DEPTH_DEF) begin
          shuffle_store[list_len] = c;
          list_len++;
          apply_request = 1'b1;
        end
      end
      MODE_SWAP: begin
        if (fix_pos < list_len) begin
          span = list_len - fix_pos;
          j = fix_pos + (r % span);
          held = shuffle_store[fix_pos];
          shuffle_store[fix_pos] = shuffle_store[j];
          shuffle_store[j] = held;
          fix_pos++;
          apply_request = 1'b1;
        end
      end
      MODE_EMIT: begin
        if (predict) begin
          for (int k = 0; k < list_len; k++) begin
            e.code = shuffle_store[k];
            e.pos  = POS_W'(k);
            e.last = (k == list_len - 1);
            note_entry(e);
          end
        end
        list_len = 0;
        fix_pos = 0;
        apply_request = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input logic [MODE_W-1:0] m, input logic [ITEM_W-1:0] c,
                          input logic [RAND_W-1:0] r, input int exp_n = -1,
                          input logic [OUT_CODE_W-1:0] exp_code = '0);
    int gap;
    entry_t e;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.item_code   <= c;
    in_ch.random_word <= r;
    do @(posedge clk); while (!in_ch.ready);
    void'(apply_request(m, c, r, exp_n < 0));
    taken_count++;
    if (exp_n == 1) begin
      e.code = exp_code;
      e.pos  = '0;
      e.last = 1'b1;
      note_entry(e);
    end
  endtask

  function automatic logic [RAND_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_noise();
    send_req(MODE_UNUSED, ITEM_W'($urandom), $urandom);
  endtask

  // load a list, shuffle it (sometimes only partly), then emit it
  task automatic run_sequence();
    int n;
    int steps;
    steady_run = ($urandom_range(0, 4) == 0);
    if (!full_list_done) begin
      n = STORE_DEPTH_DEF + 3;
      full_list_done = 1'b1;
    end else begin
      n = $urandom_range(1, 8);
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) send_noise();
      send_req(MODE_LOAD, ITEM_W'($urandom), $urandom);
    end
    if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, n + 2);
    else steps = n + $urandom_range(0, 2);
    for (int k = 0; k < steps; k++) begin
      if ($urandom_range(0, 9) == 0) send_req(MODE_LOAD, ITEM_W'($urandom), $urandom);
      if ($urandom_range(0, 24) == 0) send_noise();
      send_req(MODE_SWAP, ITEM_W'($urandom), pick_word());
    end
    send_req(MODE_EMIT, ITEM_W'($urandom), $urandom);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!steady_run && $urandom_range(0, 99) < 35) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_count() == 0) begin
        $display("%0t: unexpected entry code %0h pos %0d last %0b", $time,
                 out_ch.out_code, out_ch.out_position, out_ch.last);
        fail_count++;
      end else begin
        want_entry = pending_entries[entry_rd % ENTRY_DEPTH];
        entry_rd++;
        if (out_ch.out_code !== want_entry.code) begin
          $display("%0t: out_code expected %0h got %0h", $time,
                   want_entry.code, out_ch.out_code);
          fail_count++;
        end
        if (out_ch.out_position !== want_entry.pos) begin
          $display("%0t: out_position expected %0d got %0d", $time,
                   want_entry.pos, out_ch.out_position);
          fail_count++;
        end
        if (out_ch.last !== want_entry.last) begin
          $display("%0t: last expected %0b got %0b", $time,
                   want_entry.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_count = 0;
    taken_count = 0;
    steady_run = 1'b0;
    full_list_done = 1'b0;
    list_len = 0;
    fix_pos = 0;
    entry_wr = 0;
    entry_rd = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.item_code = '0;
    in_ch.random_word = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      send_req(DIR_ROWS[i].mode, DIR_ROWS[i].code, DIR_ROWS[i].rnd,
               DIR_ROWS[i].exp_n, DIR_ROWS[i].exp_code);
    end

    while (taken_count < TARGET_TAKEN) run_sequence();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    steady_run = 1'b0;
    while (pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_count() != 0) begin
      $display("%0t: %0d entries never arrived", $time, pending_count());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
